FILE: rtl/cae_pkg.sv
// Shared types, command codes and flag positions for the ALU and register execute core.
package cae_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] STATUS_RESET = 8'h36;

   localparam logic [2:0] FLAG_C = 3'd0;
   localparam logic [2:0] FLAG_Z = 3'd1;
   localparam logic [2:0] FLAG_I = 3'd2;
   localparam logic [2:0] FLAG_D = 3'd3;
   localparam logic [2:0] FLAG_V = 3'd6;
   localparam logic [2:0] FLAG_N = 3'd7;

   typedef enum logic [5:0] {
      CMD_ADC     = 6'd0,
      CMD_SBC     = 6'd1,
      CMD_AND     = 6'd2,
      CMD_ORA     = 6'd3,
      CMD_EOR     = 6'd4,
      CMD_CMP     = 6'd5,
      CMD_CPX     = 6'd6,
      CMD_CPY     = 6'd7,
      CMD_BIT     = 6'd8,
      CMD_ASL_A   = 6'd9,
      CMD_ASL_M   = 6'd10,
      CMD_LSR_A   = 6'd11,
      CMD_LSR_M   = 6'd12,
      CMD_ROL_A   = 6'd13,
      CMD_ROL_M   = 6'd14,
      CMD_ROR_A   = 6'd15,
      CMD_ROR_M   = 6'd16,
      CMD_INC     = 6'd17,
      CMD_DEC     = 6'd18,
      CMD_INX     = 6'd19,
      CMD_INY     = 6'd20,
      CMD_DEX     = 6'd21,
      CMD_DEY     = 6'd22,
      CMD_LDA     = 6'd23,
      CMD_LDX     = 6'd24,
      CMD_LDY     = 6'd25,
      CMD_TAX     = 6'd26,
      CMD_TAY     = 6'd27,
      CMD_TXA     = 6'd28,
      CMD_TYA     = 6'd29,
      CMD_STA     = 6'd30,
      CMD_STX     = 6'd31,
      CMD_STY     = 6'd32,
      CMD_CLC     = 6'd33,
      CMD_SEC     = 6'd34,
      CMD_CLD     = 6'd35,
      CMD_SED     = 6'd36,
      CMD_CLI     = 6'd37,
      CMD_SEI     = 6'd38,
      CMD_CLV     = 6'd39,
      CMD_PLA     = 6'd40,
      CMD_PLP     = 6'd41
   } cmd_type;

   typedef enum logic [3:0] {
      UNIT_ADD,
      UNIT_SUB,
      UNIT_AND,
      UNIT_OR,
      UNIT_XOR,
      UNIT_CMP,
      UNIT_BIT,
      UNIT_SHIFT,
      UNIT_INC,
      UNIT_DEC,
      UNIT_PASS,
      UNIT_FLAG,
      UNIT_PLP,
      UNIT_NOP
   } unit_type;

   typedef enum logic [1:0] {
      SRC_A,
      SRC_X,
      SRC_Y,
      SRC_M
   } src_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_A,
      DST_X,
      DST_Y,
      DST_MEM
   } dst_type;

   typedef enum logic [1:0] {
      SHIFT_ASL,
      SHIFT_LSR,
      SHIFT_ROL,
      SHIFT_ROR
   } shift_type;

   typedef struct packed {
      unit_type   unit;
      src_type    src;
      dst_type    dst;
      shift_type  shift;
      logic       set_zn;
      logic [2:0] flag_sel;
      logic       flag_val;
      logic [7:0] operand;
      logic [2:0] branch_cond;
   } item_type;

endpackage

FILE: rtl/cae_front.sv
// Front end: accepts requests, decodes the command and hands the decoded request to the queue.
module cae_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [5:0]        req_cmd,
   input  logic [7:0]        req_operand,
   input  logic [2:0]        req_branch_cond,
   input  logic              q_full,
   output logic              q_push,
   output cae_pkg::item_type q_item
);
   import cae_pkg::*;

   item_type dec_in;
   item_type item_ff;
   logic     valid_ff;
   logic     valid_in;
   logic     advance;

   always_comb begin
      dec_in             = '0;
      dec_in.unit        = UNIT_NOP;
      dec_in.src         = SRC_M;
      dec_in.dst         = DST_NONE;
      dec_in.shift       = SHIFT_ASL;
      dec_in.set_zn      = 1'b1;
      dec_in.flag_sel    = FLAG_C;
      dec_in.flag_val    = 1'b0;
      dec_in.operand     = req_operand;
      dec_in.branch_cond = req_branch_cond;
      case (req_cmd)
         CMD_ADC: dec_in.unit = UNIT_ADD;
         CMD_SBC: dec_in.unit = UNIT_SUB;
         CMD_AND: begin
            dec_in.unit = UNIT_AND;
            dec_in.dst  = DST_A;
         end
         CMD_ORA: begin
            dec_in.unit = UNIT_OR;
            dec_in.dst  = DST_A;
         end
         CMD_EOR: begin
            dec_in.unit = UNIT_XOR;
            dec_in.dst  = DST_A;
         end
         CMD_CMP: begin
            dec_in.unit = UNIT_CMP;
            dec_in.src  = SRC_A;
         end
         CMD_CPX: begin
            dec_in.unit = UNIT_CMP;
            dec_in.src  = SRC_X;
         end
         CMD_CPY: begin
            dec_in.unit = UNIT_CMP;
            dec_in.src  = SRC_Y;
         end
         CMD_BIT: dec_in.unit = UNIT_BIT;
         CMD_ASL_A, CMD_LSR_A, CMD_ROL_A, CMD_ROR_A: begin
            dec_in.unit = UNIT_SHIFT;
            dec_in.src  = SRC_A;
            dec_in.dst  = DST_A;
         end
         CMD_ASL_M, CMD_LSR_M, CMD_ROL_M, CMD_ROR_M: begin
            dec_in.unit = UNIT_SHIFT;
            dec_in.dst  = DST_MEM;
         end
         CMD_INC: begin
            dec_in.unit = UNIT_INC;
            dec_in.dst  = DST_MEM;
         end
         CMD_DEC: begin
            dec_in.unit = UNIT_DEC;
            dec_in.dst  = DST_MEM;
         end
         CMD_INX: begin
            dec_in.unit = UNIT_INC;
            dec_in.src  = SRC_X;
            dec_in.dst  = DST_X;
         end
         CMD_INY: begin
            dec_in.unit = UNIT_INC;
            dec_in.src  = SRC_Y;
            dec_in.dst  = DST_Y;
         end
         CMD_DEX: begin
            dec_in.unit = UNIT_DEC;
            dec_in.src  = SRC_X;
            dec_in.dst  = DST_X;
         end
         CMD_DEY: begin
            dec_in.unit = UNIT_DEC;
            dec_in.src  = SRC_Y;
            dec_in.dst  = DST_Y;
         end
         CMD_LDA, CMD_PLA: begin
            dec_in.unit = UNIT_PASS;
            dec_in.dst  = DST_A;
         end
         CMD_LDX: begin
            dec_in.unit = UNIT_PASS;
            dec_in.dst  = DST_X;
         end
         CMD_LDY: begin
            dec_in.unit = UNIT_PASS;
            dec_in.dst  = DST_Y;
         end
         CMD_TAX: begin
            dec_in.unit = UNIT_PASS;
            dec_in.src  = SRC_A;
            dec_in.dst  = DST_X;
         end
         CMD_TAY: begin
            dec_in.unit = UNIT_PASS;
            dec_in.src  = SRC_A;
            dec_in.dst  = DST_Y;
         end
         CMD_TXA: begin
            dec_in.unit = UNIT_PASS;
            dec_in.src  = SRC_X;
            dec_in.dst  = DST_A;
         end
         CMD_TYA: begin
            dec_in.unit = UNIT_PASS;
            dec_in.src  = SRC_Y;
            dec_in.dst  = DST_A;
         end
         CMD_STA: begin
            dec_in.unit   = UNIT_PASS;
            dec_in.src    = SRC_A;
            dec_in.dst    = DST_MEM;
            dec_in.set_zn = 1'b0;
         end
         CMD_STX: begin
            dec_in.unit   = UNIT_PASS;
            dec_in.src    = SRC_X;
            dec_in.dst    = DST_MEM;
            dec_in.set_zn = 1'b0;
         end
         CMD_STY: begin
            dec_in.unit   = UNIT_PASS;
            dec_in.src    = SRC_Y;
            dec_in.dst    = DST_MEM;
            dec_in.set_zn = 1'b0;
         end
         CMD_CLC: dec_in.unit = UNIT_FLAG;
         CMD_SEC: begin
            dec_in.unit     = UNIT_FLAG;
            dec_in.flag_val = 1'b1;
         end
         CMD_CLD: begin
            dec_in.unit     = UNIT_FLAG;
            dec_in.flag_sel = FLAG_D;
         end
         CMD_SED: begin
            dec_in.unit     = UNIT_FLAG;
            dec_in.flag_sel = FLAG_D;
            dec_in.flag_val = 1'b1;
         end
         CMD_CLI: begin
            dec_in.unit     = UNIT_FLAG;
            dec_in.flag_sel = FLAG_I;
         end
         CMD_SEI: begin
            dec_in.unit     = UNIT_FLAG;
            dec_in.flag_sel = FLAG_I;
            dec_in.flag_val = 1'b1;
         end
         CMD_CLV: begin
            dec_in.unit     = UNIT_FLAG;
            dec_in.flag_sel = FLAG_V;
         end
         CMD_PLP: dec_in.unit = UNIT_PLP;
         default: dec_in.unit = UNIT_NOP;
      endcase
      case (req_cmd)
         CMD_LSR_A, CMD_LSR_M: dec_in.shift = SHIFT_LSR;
         CMD_ROL_A, CMD_ROL_M: dec_in.shift = SHIFT_ROL;
         CMD_ROR_A, CMD_ROR_M: dec_in.shift = SHIFT_ROR;
         default:              dec_in.shift = SHIFT_ASL;
      endcase
   end

   assign q_push   = valid_ff && !q_full;
   assign req_full = valid_ff && q_full;
   assign advance  = req_push && !req_full;
   assign valid_in = advance || (valid_ff && q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= dec_in;
      end
   end

   assign q_item = item_ff;

endmodule

FILE: rtl/cae_queue.sv
// Short queue of decoded requests between the front end and the execute stage.
module cae_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cae_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output cae_pkg::item_type pop_item,
   output logic              empty
);
   import cae_pkg::*;

   item_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full     = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: rtl/cae_back.sv
// Execute stage: holds A, X, Y and status, runs one decoded request and registers the response.
module cae_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  cae_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_acc_out,
   output logic [7:0]        rsp_x_out,
   output logic [7:0]        rsp_y_out,
   output logic [7:0]        rsp_status_out,
   output logic              rsp_mem_write,
   output logic [7:0]        rsp_mem_data,
   output logic              rsp_branch_taken
);
   import cae_pkg::*;

   logic [7:0] acc_ff, x_ff, y_ff, status_ff;
   logic [7:0] acc_in, x_in, y_in, status_in;
   logic       out_valid_ff, out_valid_in;
   logic       mem_write_ff, mem_write_in;
   logic [7:0] mem_data_ff, mem_data_in;
   logic       taken_ff, taken_in;
   logic       fire;

   logic [7:0] m;
   logic [7:0] src_val;
   logic [7:0] res;
   logic       do_zn;
   logic       carry;
   logic       dec_mode;
   logic [8:0] bin_sum;
   logic [4:0] lo_sum;
   logic [9:0] dsum1, dsum2;
   logic [9:0] diff;
   logic       lo_borrow;
   logic [9:0] ddiff1, ddiff2;
   logic [8:0] cmp_diff;
   logic       flag_set;

   assign fire         = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop        = fire;
   assign out_valid_in = fire || (out_valid_ff && !rsp_pop);
   assign m            = q_item.operand;
   assign carry        = status_ff[FLAG_C];
   assign dec_mode     = status_ff[FLAG_D];

   always_comb begin
      case (q_item.src)
         SRC_A:   src_val = acc_ff;
         SRC_X:   src_val = x_ff;
         SRC_Y:   src_val = y_ff;
         default: src_val = m;
      endcase
   end

   always_comb begin
      bin_sum = {1'b0, acc_ff} + {1'b0, m} + {8'd0, carry};
      lo_sum  = {1'b0, acc_ff[3:0]} + {1'b0, m[3:0]} + {4'd0, carry};
      dsum1   = (dec_mode && lo_sum > 5'd9) ? {1'b0, bin_sum} + 10'h006 : {1'b0, bin_sum};
      dsum2   = (dec_mode && dsum1 > 10'h099) ? dsum1 + 10'h060 : dsum1;

      diff      = {2'b00, acc_ff} - {2'b00, m} - {9'd0, !carry};
      lo_borrow = {1'b0, acc_ff[3:0]} < ({1'b0, m[3:0]} + {4'd0, !carry});
      ddiff1    = (dec_mode && lo_borrow) ? diff - 10'h006 : diff;
      ddiff2    = (dec_mode && (ddiff1[9] || ddiff1[8:0] > 9'h099))
                ? ddiff1 - 10'h060 : ddiff1;

      cmp_diff = {1'b0, src_val} - {1'b0, m};
   end

   always_comb begin
      case (q_item.branch_cond[2:1])
         2'd0:    flag_set = status_ff[FLAG_C];
         2'd1:    flag_set = status_ff[FLAG_Z];
         2'd2:    flag_set = status_ff[FLAG_N];
         default: flag_set = status_ff[FLAG_V];
      endcase
      taken_in = q_item.branch_cond[0] ? flag_set : !flag_set;
   end

   always_comb begin
      acc_in       = acc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      status_in    = status_ff;
      mem_write_in = 1'b0;
      mem_data_in  = 8'd0;
      res          = src_val;
      do_zn        = 1'b0;
      case (q_item.unit)
         UNIT_ADD: begin
            res               = bin_sum[7:0];
            do_zn             = 1'b1;
            status_in[FLAG_V] = (acc_ff[7] ^ bin_sum[7]) & (acc_ff[7] ^ m[7]);
            status_in[FLAG_C] = |dsum2[9:8];
            acc_in            = dsum2[7:0];
         end
         UNIT_SUB: begin
            res               = diff[7:0];
            do_zn             = 1'b1;
            status_in[FLAG_V] = (acc_ff[7] ^ diff[7]) & (acc_ff[7] ^ m[7]);
            status_in[FLAG_C] = !ddiff2[9];
            acc_in            = ddiff2[7:0];
         end
         UNIT_AND: begin
            res   = acc_ff & m;
            do_zn = 1'b1;
         end
         UNIT_OR: begin
            res   = acc_ff | m;
            do_zn = 1'b1;
         end
         UNIT_XOR: begin
            res   = acc_ff ^ m;
            do_zn = 1'b1;
         end
         UNIT_CMP: begin
            res               = cmp_diff[7:0];
            do_zn             = 1'b1;
            status_in[FLAG_C] = !cmp_diff[8];
         end
         UNIT_BIT: begin
            status_in[FLAG_Z] = (acc_ff & m) == 8'd0;
            status_in[FLAG_N] = m[7];
            status_in[FLAG_V] = m[6];
         end
         UNIT_SHIFT: begin
            do_zn = 1'b1;
            case (q_item.shift)
               SHIFT_ASL: begin
                  status_in[FLAG_C] = src_val[7];
                  res               = {src_val[6:0], 1'b0};
               end
               SHIFT_LSR: begin
                  status_in[FLAG_C] = src_val[0];
                  res               = {1'b0, src_val[7:1]};
               end
               SHIFT_ROL: begin
                  status_in[FLAG_C] = src_val[7];
                  res               = {src_val[6:0], carry};
               end
               default: begin
                  status_in[FLAG_C] = src_val[0];
                  res               = {carry, src_val[7:1]};
               end
            endcase
         end
         UNIT_INC: begin
            res   = src_val + 8'd1;
            do_zn = 1'b1;
         end
         UNIT_DEC: begin
            res   = src_val - 8'd1;
            do_zn = 1'b1;
         end
         UNIT_PASS: begin
            res   = src_val;
            do_zn = q_item.set_zn;
         end
         UNIT_FLAG: status_in[q_item.flag_sel] = q_item.flag_val;
         UNIT_PLP:  status_in = m;
         default:   res = src_val;
      endcase
      if (do_zn) begin
         status_in[FLAG_Z] = res == 8'd0;
         status_in[FLAG_N] = res[7];
      end
      case (q_item.dst)
         DST_A: acc_in = res;
         DST_X: x_in   = res;
         DST_Y: y_in   = res;
         DST_MEM: begin
            mem_write_in = 1'b1;
            mem_data_in  = res;
         end
         default: mem_write_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 8'd0;
         x_ff         <= 8'd0;
         y_ff         <= 8'd0;
         status_ff    <= STATUS_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            acc_ff    <= acc_in;
            x_ff      <= x_in;
            y_ff      <= y_in;
            status_ff <= status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         mem_write_ff <= mem_write_in;
         mem_data_ff  <= mem_data_in;
         taken_ff     <= taken_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_acc_out      = acc_ff;
   assign rsp_x_out        = x_ff;
   assign rsp_y_out        = y_ff;
   assign rsp_status_out   = status_ff;
   assign rsp_mem_write    = mem_write_ff;
   assign rsp_mem_data     = mem_data_ff;
   assign rsp_branch_taken = taken_ff;

endmodule

FILE: rtl/cpu_alu_register_execute_core.sv
// Top level of the eight-bit ALU and register execute core.
// Takes one request per clock while full is low and returns one response per request, in
// order. A request passes the decode register, a four-entry queue and the execute stage,
// whose output register holds the response. The sustained rate is one request per cycle
// while responses are popped, as the execute stage updates A, X, Y and status for each
// request in turn and takes a new request as soon as its held response is popped.
// Stalls on the response side fill the queue before full is raised.
module cpu_alu_register_execute_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [5:0] req_cmd,
   input  logic [7:0] req_operand,
   input  logic [2:0] req_branch_cond,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_acc_out,
   output logic [7:0] rsp_x_out,
   output logic [7:0] rsp_y_out,
   output logic [7:0] rsp_status_out,
   output logic       rsp_mem_write,
   output logic [7:0] rsp_mem_data,
   output logic       rsp_branch_taken
);
   import cae_pkg::*;

   item_type front_item;
   item_type back_item;
   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;

   cae_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_operand     (req_operand),
      .req_branch_cond (req_branch_cond),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (front_item)
   );

   cae_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .empty     (q_empty)
   );

   cae_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_item           (back_item),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_acc_out      (rsp_acc_out),
      .rsp_x_out        (rsp_x_out),
      .rsp_y_out        (rsp_y_out),
      .rsp_status_out   (rsp_status_out),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_mem_data     (rsp_mem_data),
      .rsp_branch_taken (rsp_branch_taken)
   );

endmodule

FILE: tb/tb_cpu_alu_register_execute_core.sv
// Self-checking testbench for the eight-bit ALU and register execute core.
`timescale 1ns / 1ps

module tb_cpu_alu_register_execute_core;
   import cae_pkg::*;

   localparam int RANDOM_ITEMS = 650;
   localparam int HOLD_LEN     = 150;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic [5:0] cmd;
      logic [7:0] operand;
      logic [2:0] cond;
   } alu_request_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] status;
      logic       mem_write;
      logic [7:0] mem_data;
      logic       branch_taken;
   } reg_snapshot_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [5:0] req_cmd = '0;
   logic [7:0] req_operand = '0;
   logic [2:0] req_branch_cond = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_acc_out;
   logic [7:0] rsp_x_out;
   logic [7:0] rsp_y_out;
   logic [7:0] rsp_status_out;
   logic       rsp_mem_write;
   logic [7:0] rsp_mem_data;
   logic       rsp_branch_taken;

   alu_request_type  request_q[$];
   reg_snapshot_type snapshot_q[$];

   logic [7:0] sim_a;
   logic [7:0] sim_x;
   logic [7:0] sim_y;
   logic [7:0] sim_p;

   int n_total     = 0;
   int n_accepted  = 0;
   int phase;
   int hold_cnt;
   logic hold_done;
   int stall_cycles;
   int n_mismatch  = 0;
   logic timed_out;

   cpu_alu_register_execute_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cmd          (req_cmd),
      .req_operand      (req_operand),
      .req_branch_cond  (req_branch_cond),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_acc_out      (rsp_acc_out),
      .rsp_x_out        (rsp_x_out),
      .rsp_y_out        (rsp_y_out),
      .rsp_status_out   (rsp_status_out),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_mem_data     (rsp_mem_data),
      .rsp_branch_taken (rsp_branch_taken)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] set_zn(input logic [7:0] v);
      sim_p[FLAG_Z] = (v == 8'h00);
      sim_p[FLAG_N] = v[7];
      return v;
   endfunction

   function automatic logic [7:0] shift8(input shift_type kind, input logic [7:0] v,
                                         input logic cin);
      logic [7:0] r;
      case (kind)
         SHIFT_ASL: begin
            sim_p[FLAG_C] = v[7];
            r = {v[6:0], 1'b0};
         end
         SHIFT_LSR: begin
            sim_p[FLAG_C] = v[0];
            r = {1'b0, v[7:1]};
         end
         SHIFT_ROL: begin
            sim_p[FLAG_C] = v[7];
            r = {v[6:0], cin};
         end
         default: begin
            sim_p[FLAG_C] = v[0];
            r = {cin, v[7:1]};
         end
      endcase
      return set_zn(r);
   endfunction

   function automatic void compare8(input logic [7:0] r, input logic [7:0] m);
      logic [7:0] diff;
      diff = r - m;
      void'(set_zn(diff));
      sim_p[FLAG_C] = (r >= m);
   endfunction

   function automatic reg_snapshot_type alu_execute(input logic [5:0] cmd,
                                                    input logic [7:0] m,
                                                    input logic [2:0] cond);
      reg_snapshot_type res;
      logic taken;
      logic sel;
      logic cin;
      logic wr;
      logic [7:0] wd;
      int a;
      int b;
      int t;
      case (cond[2:1])
         2'd0:    sel = sim_p[FLAG_C];
         2'd1:    sel = sim_p[FLAG_Z];
         2'd2:    sel = sim_p[FLAG_N];
         default: sel = sim_p[FLAG_V];
      endcase
      taken = cond[0] ? sel : !sel;
      cin = sim_p[FLAG_C];
      wr = 1'b0;
      wd = 8'h00;
      a = sim_a;
      case (cmd)
         CMD_ADC: begin
            b = cin;
            t = a + m + b;
            void'(set_zn(t[7:0]));
            sim_p[FLAG_V] = (((a ^ t) & (a ^ m)) & 32'h80) != 0;
            if (sim_p[FLAG_D]) begin
               if ((a & 15) + (m & 15) + b > 9) t = t + 6;
               if (t > 32'h99) t = t + 32'h60;
            end
            sim_p[FLAG_C] = (t > 32'hff);
            sim_a = t[7:0];
         end
         CMD_SBC: begin
            b = cin ? 0 : 1;
            t = a - m - b;
            void'(set_zn(t[7:0]));
            sim_p[FLAG_V] = (((a ^ t) & (a ^ m)) & 32'h80) != 0;
            if (sim_p[FLAG_D]) begin
               if ((a & 15) - b < int'(m & 15)) t = t - 6;
               if (t < 0 || t > 32'h99) t = t - 32'h60;
            end
            sim_p[FLAG_C] = (t >= 0);
            sim_a = t[7:0];
         end
         CMD_AND:   sim_a = set_zn(sim_a & m);
         CMD_ORA:   sim_a = set_zn(sim_a | m);
         CMD_EOR:   sim_a = set_zn(sim_a ^ m);
         CMD_CMP:   compare8(sim_a, m);
         CMD_CPX:   compare8(sim_x, m);
         CMD_CPY:   compare8(sim_y, m);
         CMD_BIT: begin
            sim_p[FLAG_Z] = ((sim_a & m) == 8'h00);
            sim_p[FLAG_N] = m[7];
            sim_p[FLAG_V] = m[6];
         end
         CMD_ASL_A: sim_a = shift8(SHIFT_ASL, sim_a, cin);
         CMD_LSR_A: sim_a = shift8(SHIFT_LSR, sim_a, cin);
         CMD_ROL_A: sim_a = shift8(SHIFT_ROL, sim_a, cin);
         CMD_ROR_A: sim_a = shift8(SHIFT_ROR, sim_a, cin);
         CMD_ASL_M: begin wr = 1'b1; wd = shift8(SHIFT_ASL, m, cin); end
         CMD_LSR_M: begin wr = 1'b1; wd = shift8(SHIFT_LSR, m, cin); end
         CMD_ROL_M: begin wr = 1'b1; wd = shift8(SHIFT_ROL, m, cin); end
         CMD_ROR_M: begin wr = 1'b1; wd = shift8(SHIFT_ROR, m, cin); end
         CMD_INC:   begin wr = 1'b1; wd = set_zn(m + 8'd1); end
         CMD_DEC:   begin wr = 1'b1; wd = set_zn(m - 8'd1); end
         CMD_INX:   sim_x = set_zn(sim_x + 8'd1);
         CMD_INY:   sim_y = set_zn(sim_y + 8'd1);
         CMD_DEX:   sim_x = set_zn(sim_x - 8'd1);
         CMD_DEY:   sim_y = set_zn(sim_y - 8'd1);
         CMD_LDA:   sim_a = set_zn(m);
         CMD_LDX:   sim_x = set_zn(m);
         CMD_LDY:   sim_y = set_zn(m);
         CMD_TAX:   sim_x = set_zn(sim_a);
         CMD_TAY:   sim_y = set_zn(sim_a);
         CMD_TXA:   sim_a = set_zn(sim_x);
         CMD_TYA:   sim_a = set_zn(sim_y);
         CMD_STA:   begin wr = 1'b1; wd = sim_a; end
         CMD_STX:   begin wr = 1'b1; wd = sim_x; end
         CMD_STY:   begin wr = 1'b1; wd = sim_y; end
         CMD_CLC:   sim_p[FLAG_C] = 1'b0;
         CMD_SEC:   sim_p[FLAG_C] = 1'b1;
         CMD_CLD:   sim_p[FLAG_D] = 1'b0;
         CMD_SED:   sim_p[FLAG_D] = 1'b1;
         CMD_CLI:   sim_p[FLAG_I] = 1'b0;
         CMD_SEI:   sim_p[FLAG_I] = 1'b1;
         CMD_CLV:   sim_p[FLAG_V] = 1'b0;
         CMD_PLA:   sim_a = set_zn(m);
         CMD_PLP:   sim_p = m;
         default:   ;
      endcase
      res.acc          = sim_a;
      res.x            = sim_x;
      res.y            = sim_y;
      res.status       = sim_p;
      res.mem_write    = wr;
      res.mem_data     = wr ? wd : 8'h00;
      res.branch_taken = taken;
      return res;
   endfunction

   task automatic add_request(input logic [5:0] cmd, input logic [7:0] operand,
                              input logic [2:0] cond);
      alu_request_type r;
      r.cmd = cmd;
      r.operand = operand;
      r.cond = cond;
      request_q.push_back(r);
   endtask

   function automatic logic [7:0] pick_operand();
      logic [7:0] corners[8];
      corners = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff, 8'h99, 8'h09};
      if ($urandom_range(99) < 20) return corners[$urandom_range(7)];
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [5:0] pick_decimal_cmd();
      case ($urandom_range(5))
         0:       return CMD_SED;
         1:       return CMD_CLD;
         2:       return CMD_SEC;
         3:       return CMD_CLC;
         4:       return CMD_SBC;
         default: return CMD_ADC;
      endcase
   endfunction

   function automatic int send_idle_pct(input int ph);
      case (ph)
         0:       return 8;
         1:       return 87;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct(input int ph);
      case (ph)
         0:       return 87;
         1:       return 8;
         default: return 0;
      endcase
   endfunction

   always_comb begin
      if (n_total == 0) phase = 0;
      else if (n_accepted * 3 / n_total > 2) phase = 2;
      else phase = n_accepted * 3 / n_total;
   end

   // driver: hold the offered request until accepted
   always @(posedge clock) begin
      alu_request_type nxt;
      if (reset) begin
         req_push <= 1'b0;
         req_cmd <= '0;
         req_operand <= '0;
         req_branch_cond <= '0;
         sim_a = 8'h00;
         sim_x = 8'h00;
         sim_y = 8'h00;
         sim_p = STATUS_RESET;
      end else begin
         if (req_push && !req_full) begin
            snapshot_q.push_back(alu_execute(req_cmd, req_operand, req_branch_cond));
            n_accepted <= n_accepted + 1;
         end
         if (!req_push || !req_full) begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct(phase)) begin
               nxt = request_q.pop_front();
               req_cmd <= nxt.cmd;
               req_operand <= nxt.operand;
               req_branch_cond <= nxt.cond;
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off at the start of the final phase
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && phase == 2) begin
         hold_cnt <= hold_cnt + 1;
         if (hold_cnt == HOLD_LEN - 1) hold_done <= 1'b1;
      end
   end

   // monitor: compare each popped response with the oldest prediction
   always @(posedge clock) begin
      reg_snapshot_type got;
      reg_snapshot_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got.acc          = rsp_acc_out;
            got.x            = rsp_x_out;
            got.y            = rsp_y_out;
            got.status       = rsp_status_out;
            got.mem_write    = rsp_mem_write;
            got.mem_data     = rsp_mem_data;
            got.branch_taken = rsp_branch_taken;
            if (snapshot_q.size() == 0) begin
               n_mismatch <= n_mismatch + 1;
               if (n_mismatch < MAX_REPORTS)
                  $display("unexpected response acc=%h x=%h y=%h p=%h wr=%b md=%h br=%b",
                           got.acc, got.x, got.y, got.status, got.mem_write,
                           got.mem_data, got.branch_taken);
            end else begin
               want = snapshot_q.pop_front();
               if (got.acc !== want.acc || got.x !== want.x || got.y !== want.y ||
                   got.status !== want.status || got.mem_write !== want.mem_write ||
                   got.mem_data !== want.mem_data ||
                   got.branch_taken !== want.branch_taken) begin
                  n_mismatch <= n_mismatch + 1;
                  if (n_mismatch < MAX_REPORTS) begin
                     $display("mismatch exp acc=%h x=%h y=%h p=%h wr=%b md=%h br=%b",
                              want.acc, want.x, want.y, want.status, want.mem_write,
                              want.mem_data, want.branch_taken);
                     $display("         got acc=%h x=%h y=%h p=%h wr=%b md=%h br=%b",
                              got.acc, got.x, got.y, got.status, got.mem_write,
                              got.mem_data, got.branch_taken);
                  end
               end
            end
         end
         rsp_pop <= !(phase == 2 && !hold_done) &&
                    ($urandom_range(99) >= recv_idle_pct(phase));
      end
   end

   always @(posedge clock) begin
      if (reset) stall_cycles <= 0;
      else if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      int n_real;
      logic [5:0] cmd;
      int roll;
      add_request(CMD_LDA, 8'h00, 3'd3);
      add_request(CMD_LDA, 8'hff, 3'd5);
      add_request(CMD_LDA, 8'h58, 3'd7);
      add_request(CMD_SED, 8'h00, 3'd0);
      add_request(CMD_SEC, 8'hff, 3'd1);
      add_request(CMD_ADC, 8'h46, 3'd2);
      add_request(CMD_ADC, 8'h99, 3'd1);
      add_request(CMD_SBC, 8'h12, 3'd0);
      add_request(CMD_SBC, 8'hff, 3'd6);
      add_request(CMD_CLD, 8'h00, 3'd4);
      add_request(CMD_CLC, 8'h00, 3'd0);
      add_request(CMD_ADC, 8'h7f, 3'd7);
      add_request(CMD_SBC, 8'h80, 3'd6);
      add_request(CMD_LSR_M, 8'h01, 3'd3);
      add_request(CMD_ROL_M, 8'h80, 3'd1);
      add_request(CMD_ROR_M, 8'h01, 3'd5);
      add_request(CMD_INC, 8'hff, 3'd2);
      add_request(CMD_DEC, 8'h00, 3'd4);
      add_request(CMD_TAX, 8'h00, 3'd3);
      add_request(CMD_DEX, 8'h00, 3'd5);
      add_request(CMD_STX, 8'h00, 3'd0);
      add_request(CMD_PLP, 8'hff, 3'd6);
      add_request(CMD_PLP, 8'h00, 3'd7);
      add_request(6'd63, 8'hff, 3'd7);
      add_request(CMD_CMP, 8'h00, 3'd1);
      add_request(CMD_BIT, 8'hc0, 3'd2);
      n_real = 0;
      while (n_real < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            cmd = 6'($urandom_range(63, 42));
         end else begin
            if (roll < 30) cmd = pick_decimal_cmd();
            else cmd = 6'($urandom_range(41));
         end
         n_real++;
         add_request(cmd, pick_operand(), 3'($urandom_range(7)));
      end
      n_total = request_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (!(request_q.size() == 0 && !req_push && snapshot_q.size() == 0) &&
             stall_cycles < STALL_LIMIT)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      timed_out = (stall_cycles >= STALL_LIMIT);

      if (!timed_out && n_mismatch == 0 && snapshot_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
